// ===== src/vpdr_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the pose tracker.
package vpdr_pkg;

    localparam int CORD_W = 34;
    localparam int TRIG_W = 35;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORD_W-1:0] EIGHTH_TURN = 34'sd536870912;
    localparam logic [21:0] INV_TWO_PI_Q24 = 22'd2670177;
    localparam logic [19:0] TAN_LIMIT = 20'd524288;

    localparam logic [1:0] REG_MOTION_MODE = 2'd0;
    localparam logic [1:0] REG_WHEELBASE   = 2'd1;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== src/vpdr_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, gives cos and sin in Q2.30.
module vpdr_cordic #(
    parameter int STEPS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [15:0]     angle,
    output logic            done,
    output vpdr_pkg::trig_t trig
);
    import vpdr_pkg::*;

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                     run_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               quad_reg;
    logic signed [CORD_W-1:0] x_reg;
    logic signed [CORD_W-1:0] y_reg;
    logic signed [CORD_W-1:0] z_reg;

    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [CORD_W-1:0] at;
    logic signed [TRIG_W-1:0] x_ext;
    logic signed [TRIG_W-1:0] y_ext;
    logic                     last_step;

    always_comb
    begin
        dx        = y_reg >>> cnt_reg;
        dy        = x_reg >>> cnt_reg;
        at        = $signed({2'b00, atan_entry(5'(cnt_reg))});
        x_ext     = {x_reg[CORD_W-1], x_reg};
        y_ext     = {y_reg[CORD_W-1], y_reg};
        last_step = (cnt_reg == CNT_W'(STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (last_step)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({4'b0000, angle[13:0], 16'h0000}) - EIGHTH_TURN;
            quad_reg <= angle[15:14];
        end
        else if (run_reg)
        begin
            if (!z_reg[CORD_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                trig.cos_v = x_ext;
                trig.sin_v = y_ext;
            end
            2'd1:
            begin
                trig.cos_v = -y_ext;
                trig.sin_v = x_ext;
            end
            2'd2:
            begin
                trig.cos_v = -x_ext;
                trig.sin_v = -y_ext;
            end
            default:
            begin
                trig.cos_v = y_ext;
                trig.sin_v = -x_ext;
            end
        endcase
    end

    assign done = done_reg;

    ap_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg))
        else $error("cordic done without a run");
    ap_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (run_reg && cnt_reg == '0))
        else $error("cordic start did not arm the iteration");
    ap_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (cnt_reg <= CNT_W'(STEPS - 1)))
        else $error("cordic step count out of range");

endmodule

// ===== src/vehicle_pose_dead_reckoning.sv =====
// Pose tracker top level: heading update, tangent division, CORDIC and position step.
// Particle mode: heading CORDIC, x step, y step, done step. Bicycle mode first adds a steer
// CORDIC run, a 20-step tan division and a 34-step heading division on the shared restoring
// divider and the MUL_A to MUL_C multiply states; tan division is skipped if tan is 0 or saturated.
// A new beat is taken only back in idle; a result stall holds the sequencer in its last step.
// Reset (rst_n, async low) clears pose, mode and output valid; wheelbase resets to 1.0.
module vehicle_pose_dead_reckoning #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] speed, [31:16] steer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [31:0] x_out, [63:32] y_out, [79:64] heading_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import vpdr_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE       = 15'b000000000000001,
        ST_STEER_GO   = 15'b000000000000010,
        ST_STEER_WAIT = 15'b000000000000100,
        ST_TAN_CHK    = 15'b000000000001000,
        ST_TAN_DIV    = 15'b000000000010000,
        ST_MUL_A      = 15'b000000000100000,
        ST_MUL_B      = 15'b000000001000000,
        ST_MUL_C      = 15'b000000010000000,
        ST_INC_GO     = 15'b000000100000000,
        ST_INC_DIV    = 15'b000001000000000,
        ST_HEAD_GO    = 15'b000010000000000,
        ST_HEAD_WAIT  = 15'b000100000000000,
        ST_MOVE_X     = 15'b001000000000000,
        ST_MOVE_Y     = 15'b010000000000000,
        ST_DONE       = 15'b100000000000000
    } state_t;

    state_t state_reg;

    logic        mode_reg;
    logic [15:0] wheelbase_reg;

    logic signed [31:0] east_reg;
    logic signed [31:0] north_reg;
    logic [15:0]        heading_reg;

    logic signed [15:0] speed_reg;
    logic [15:0]        steer_reg;

    logic [33:0] ac_reg;
    logic [33:0] as_reg;
    logic        tneg_reg;
    logic [19:0] t_mag_reg;
    logic [35:0] pm_reg;
    logic [57:0] acc_reg;

    logic [33:0] rem_reg;
    logic [33:0] quo_reg;
    logic [33:0] dvs_reg;
    logic [5:0]  dcnt_reg;

    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;

    logic        out_valid_reg;
    logic [31:0] x_out_reg;
    logic [31:0] y_out_reg;
    logic [15:0] heading_out_reg;

    logic        cordic_start;
    logic [15:0] cordic_angle;
    logic        cordic_done;
    trig_t       trig;

    vpdr_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (cordic_angle),
        .done  (cordic_done),
        .trig  (trig)
    );

    assign cordic_start = (state_reg == ST_STEER_GO) || (state_reg == ST_HEAD_GO);
    assign cordic_angle = (state_reg == ST_STEER_GO) ? steer_reg : heading_reg;

    logic in_beat;
    logic out_free;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    // magnitudes and signs of the steer trig values
    logic [TRIG_W-1:0] c_abs;
    logic [TRIG_W-1:0] s_abs;
    always_comb
    begin
        c_abs = trig.cos_v[TRIG_W-1] ? TRIG_W'(-trig.cos_v) : TRIG_W'(trig.cos_v);
        s_abs = trig.sin_v[TRIG_W-1] ? TRIG_W'(-trig.sin_v) : TRIG_W'(trig.sin_v);
    end

    // shared restoring divider step
    logic [34:0] trial;
    logic [33:0] rem_step;
    logic [33:0] quo_step;
    logic        div_last;
    always_comb
    begin
        trial    = {1'b0, rem_reg[32:0], quo_reg[33]} - {1'b0, dvs_reg};
        rem_step = trial[34] ? {rem_reg[32:0], quo_reg[33]} : trial[33:0];
        quo_step = {quo_reg[32:0], ~trial[34]};
        div_last = (dcnt_reg == 6'd1);
    end

    // half-width partial product of the 1/(2*pi) scaling, low half then high half
    logic [17:0] pm_half;
    logic [39:0] part_prod;
    always_comb
    begin
        pm_half   = (state_reg == ST_MUL_B) ? pm_reg[17:0] : pm_reg[35:18];
        part_prod = pm_half * INV_TWO_PI_Q24;
    end

    logic [15:0] speed_mag;
    logic        inc_neg;
    logic [15:0] inc_val;
    logic [15:0] heading_next;
    always_comb
    begin
        speed_mag    = speed_reg[15] ? 16'(-speed_reg) : 16'(speed_reg);
        inc_neg      = speed_reg[15] ^ tneg_reg;
        inc_val      = inc_neg ? 16'(-quo_step[15:0]) : quo_step[15:0];
        heading_next = heading_reg + inc_val;
    end

    // position step: one signed multiply shared between x and y
    logic signed [TRIG_W-1:0] trig_sel;
    logic signed [31:0]       pos_sel;
    logic signed [50:0]       mprod;
    logic signed [50:0]       mround;
    logic signed [32:0]       pos_sum;
    logic signed [31:0]       pos_new;
    always_comb
    begin
        trig_sel = (state_reg == ST_MOVE_X) ? cos_reg : sin_reg;
        pos_sel  = (state_reg == ST_MOVE_X) ? east_reg : north_reg;
        mprod    = speed_reg * trig_sel;
        mround   = mprod + 51'sd2097152;
        pos_sum  = {pos_sel[31], pos_sel} + {{4{mround[50]}}, mround[50:22]};
        if (pos_sum[32] != pos_sum[31])
        begin
            pos_new = pos_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            pos_new = pos_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            wheelbase_reg <= 16'd256;
            east_reg      <= '0;
            north_reg     <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MOTION_MODE)
                begin
                    mode_reg <= cfg_data[0];
                end
                else if (cfg_index == REG_WHEELBASE)
                begin
                    wheelbase_reg <= cfg_data;
                end
            end

            // the done step reloads the output register itself
            if (out_valid_reg && m_axis_tready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        if (!mode_reg)
                        begin
                            heading_reg <= heading_reg + s_axis_tdata[31:16];
                            state_reg   <= ST_HEAD_GO;
                        end
                        else
                        begin
                            state_reg <= ST_STEER_GO;
                        end
                    end
                end
                ST_STEER_GO:
                begin
                    state_reg <= ST_STEER_WAIT;
                end
                ST_STEER_WAIT:
                begin
                    if (cordic_done)
                    begin
                        state_reg <= ST_TAN_CHK;
                    end
                end
                ST_TAN_CHK:
                begin
                    if (as_reg == '0 || ac_reg == '0
                        || {3'b000, as_reg} >= {ac_reg, 3'b000})
                    begin
                        state_reg <= ST_MUL_A;
                    end
                    else
                    begin
                        dcnt_reg  <= 6'd20;
                        state_reg <= ST_TAN_DIV;
                    end
                end
                ST_TAN_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (div_last)
                    begin
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_MUL_A:
                begin
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B:
                begin
                    state_reg <= ST_MUL_C;
                end
                ST_MUL_C:
                begin
                    state_reg <= ST_INC_GO;
                end
                ST_INC_GO:
                begin
                    dcnt_reg  <= 6'd34;
                    state_reg <= ST_INC_DIV;
                end
                ST_INC_DIV:
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (div_last)
                    begin
                        heading_reg <= heading_next;
                        state_reg   <= ST_HEAD_GO;
                    end
                end
                ST_HEAD_GO:
                begin
                    state_reg <= ST_HEAD_WAIT;
                end
                ST_HEAD_WAIT:
                begin
                    if (cordic_done)
                    begin
                        state_reg <= ST_MOVE_X;
                    end
                end
                ST_MOVE_X:
                begin
                    east_reg  <= pos_new;
                    state_reg <= ST_MOVE_Y;
                end
                ST_MOVE_Y:
                begin
                    north_reg <= pos_new;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            speed_reg <= s_axis_tdata[15:0];
            steer_reg <= s_axis_tdata[31:16];
        end

        if (state_reg == ST_STEER_WAIT && cordic_done)
        begin
            ac_reg   <= c_abs[33:0];
            as_reg   <= s_abs[33:0];
            tneg_reg <= trig.sin_v[TRIG_W-1] ^ trig.cos_v[TRIG_W-1];
        end

        if (state_reg == ST_TAN_CHK)
        begin
            priority if (as_reg == '0)
            begin
                t_mag_reg <= '0;
            end
            else if (ac_reg == '0 || {3'b000, as_reg} >= {ac_reg, 3'b000})
            begin
                t_mag_reg <= TAN_LIMIT;
            end
            else
            begin
                // dividend is |sin| << 16; quotient fits in 20 bits
                rem_reg <= {4'b0000, as_reg[33:4]};
                quo_reg <= {as_reg[3:0], 30'b0};
                dvs_reg <= ac_reg;
            end
        end

        if (state_reg == ST_TAN_DIV || state_reg == ST_INC_DIV)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
            if (state_reg == ST_TAN_DIV && div_last)
            begin
                t_mag_reg <= quo_step[19:0];
            end
        end

        if (state_reg == ST_MUL_A)
        begin
            pm_reg <= speed_mag * t_mag_reg;
        end
        if (state_reg == ST_MUL_B)
        begin
            acc_reg <= {18'b0, part_prod};
        end
        if (state_reg == ST_MUL_C)
        begin
            acc_reg <= acc_reg + {part_prod, 18'b0};
        end

        if (state_reg == ST_INC_GO)
        begin
            // floor(floor(n / 2^24) / wb) equals floor(n / (wb * 2^24))
            rem_reg <= '0;
            quo_reg <= acc_reg[57:24];
            dvs_reg <= (wheelbase_reg == '0) ? 34'd1 : {18'b0, wheelbase_reg};
        end

        if (state_reg == ST_HEAD_WAIT && cordic_done)
        begin
            cos_reg <= trig.cos_v;
            sin_reg <= trig.sin_v;
        end

        if (state_reg == ST_DONE && out_free)
        begin
            x_out_reg       <= east_reg;
            y_out_reg       <= north_reg;
            heading_out_reg <= heading_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {heading_out_reg, y_out_reg, x_out_reg};

    ap_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the done step");
    ap_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == ST_STEER_WAIT || state_reg == ST_HEAD_WAIT))
        else $error("cordic finished while sequencer not waiting");
    ap_particle_skips_tan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && !mode_reg) |=> (state_reg == ST_HEAD_GO))
        else $error("particle step did not go straight to heading trig");
    ap_tan_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_A) |-> (t_mag_reg <= TAN_LIMIT))
        else $error("tangent magnitude above limit");
    ap_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAN_DIV || state_reg == ST_INC_DIV) |-> (dcnt_reg != '0))
        else $error("divider ran past its step count");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the dead-reckoning pose tracker.
module testbench;
    import vpdr_pkg::*;

    localparam int STEPS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        logic [15:0] heading;
    } pose_t;

    class pose_scoreboard;
        logic [31:0] east;
        logic [31:0] north;
        logic [15:0] heading;
        logic        mode;
        logic [15:0] wb;
        pose_t       pending[$];
        int          errors;

        function new();
            east = 0;
            north = 0;
            heading = 0;
            mode = 0;
            wb = 16'd256;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == REG_MOTION_MODE)
                mode = val[0];
            else if (idx == REG_WHEELBASE)
                wb = val;
        endfunction

        // Rotation on a 32-bit angle; returns cos/sin in Q2.30.
        function void rotate(logic [31:0] ang, output longint c, output longint s);
            longint xv, yv, zv, dx, dy;
            xv = 652032874;
            yv = 0;
            zv = longint'(ang[29:0]) - 64'sh20000000;
            for (int i = 0; i < STEPS && i < 24; i++)
            begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (zv >= 0)
                begin
                    xv -= dx; yv += dy; zv -= longint'(atan_entry(5'(i)));
                end
                else
                begin
                    xv += dx; yv -= dy; zv += longint'(atan_entry(5'(i)));
                end
            end
            case (ang[31:30])
                2'd0: begin c = xv;  s = yv;  end
                2'd1: begin c = -yv; s = xv;  end
                2'd2: begin c = -xv; s = -yv; end
                default: begin c = yv; s = -xv; end
            endcase
        endfunction

        function longint tangent(logic [15:0] ang);
            longint c, s, ac, as_, t;
            rotate({ang, 16'h0}, c, s);
            ac = c < 0 ? -c : c;
            as_ = s < 0 ? -s : s;
            if (as_ == 0)
                return 0;
            if (ac == 0 || as_ >= 8 * ac)
                return ((s < 0) != (c < 0)) ? -524288 : 524288;
            t = (s * 65536) / c;
            if (t > 524288) t = 524288;
            if (t < -524288) t = -524288;
            return t;
        endfunction

        function logic [31:0] step_pos(logic [31:0] pos, longint spd, longint trig);
            longint d, p;
            d = (spd * trig + (64'sd1 <<< 21)) >>> 22;
            p = longint'($signed(pos)) + d;
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            return p[31:0];
        endfunction

        function void note_input(logic [15:0] speed, logic [15:0] steer);
            longint spd, inc, wbl, c, s;
            pose_t exp_pose;
            spd = longint'($signed(speed));
            if (!mode)
                heading = heading + steer;
            else
            begin
                wbl = (wb == 0) ? 1 : longint'(wb);
                inc = (spd * tangent(steer) * 64'sd2670177) / (wbl <<< 24);
                heading = heading + inc[15:0];
            end
            rotate({heading, 16'h0}, c, s);
            east = step_pos(east, spd, c);
            north = step_pos(north, spd, s);
            exp_pose.x_pos = east;
            exp_pose.y_pos = north;
            exp_pose.heading = heading;
            pending.push_back(exp_pose);
        endfunction

        function void check_result(logic [79:0] data);
            pose_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.x_pos)
            begin
                $error("x_out expected %h got %h", e.x_pos, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.y_pos)
            begin
                $error("y_out expected %h got %h", e.y_pos, data[63:32]);
                errors++;
            end
            if (data[79:64] !== e.heading)
            begin
                $error("heading_out expected %h got %h", e.heading, data[79:64]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;

    pose_scoreboard pose_sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;

    vehicle_pose_dead_reckoning #(.CORDIC_STEPS(STEPS)) i_dut (.*);

    always #2 clk = ~clk;

    // sink side: random stalls, checks on accepted beats
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            pose_sb.check_result(m_axis_tdata);
    end

    always @(negedge clk)
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // valid stays up after a beat so the next call can follow without a gap
    task automatic send_beat(logic [15:0] speed, logic [15:0] steer);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {steer, speed};
        do @(posedge clk); while (!s_axis_tready);
        pose_sb.note_input(speed, steer);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pose_sb.pending.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        pose_sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic [15:0] rand_speed();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return 16'($signed($urandom_range(2048)) - 1024);
            default: return 16'($signed($urandom_range(800)) - 400);
        endcase
    endfunction

    function automatic logic [15:0] rand_steer();
        case ($urandom_range(4))
            0: return 16'($urandom_range(65535));
            1: return 16'($signed($urandom_range(32768)) - 16384);
            default: return 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    initial
    begin
        logic [15:0] wbs[6];
        pose_sb = new();
        wbs = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'd77, 16'd1024};
        repeat (11) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: field extremes, quadrant edges, saturation of tan
        send_beat(16'h7FFF, 16'h0000);
        send_beat(16'h8000, 16'h4000);
        send_beat(16'h0100, 16'hC000);
        send_beat(16'hFFFF, 16'h8000);
        send_beat(16'h0000, 16'h7FFF);
        for (int i = 0; i < 400; i++)
            send_beat(16'h7FFF, 16'h0000);   // drive x into positive saturation
        write_cfg(REG_MOTION_MODE, 16'd1);
        send_beat(16'h0100, 16'h4000);
        send_beat(16'h0100, 16'hC000);
        send_beat(16'hFF00, 16'h3F00);
        send_beat(16'h7FFF, 16'h2000);
        send_beat(16'h8000, 16'h8000);
        send_beat(16'h0000, 16'h1234);
        send_beat(16'h7FFF, 16'h4000);
        write_cfg(2'd3, 16'hFFFF);           // unused index, ignored
        write_cfg(REG_WHEELBASE, 16'd0);
        send_beat(16'h7FFF, 16'h3000);
        write_cfg(REG_WHEELBASE, 16'hFFFF);
        send_beat(16'h8000, 16'hD000);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            write_cfg(REG_MOTION_MODE, 16'(ph & 1));
            write_cfg(REG_WHEELBASE, wbs[ph % 6]);
            for (int i = 0; i < 30; i++)
                send_beat(rand_speed(), rand_steer());
        end

        drain();
        if (pose_sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
src/vpdr_pkg.sv
src/vpdr_cordic.sv
src/vehicle_pose_dead_reckoning.sv
test/testbench.sv
